// ===== sv/dnsa_pkg.sv =====
// Shared types and constants for the DNS reply A-record extractor.
// Used by every module of the block and by its checker; depends on nothing.
package dnsa_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] HEADER_BYTES = 16'd12;
	localparam logic [WORD_W-1:0] FIXED_BYTES  = 16'd10;
	localparam logic [WORD_W-1:0] QTAIL_BYTES  = 16'd4;
	localparam logic [WORD_W-1:0] A_DATA_BYTES = 16'd4;
	localparam logic [WORD_W-1:0] TYPE_A       = 16'd1;
	localparam logic [WORD_W-1:0] OFFSET_MAX   = 16'hFFFF;
	localparam logic [BYTE_W-1:0] PTR_MASK     = 8'hC0;

	localparam logic [CFG_IDX_W-1:0] REG_LISTEN_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID   = 1'd1;

	localparam logic [STATUS_W-1:0] ST_FOUND        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DISABLED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ID_MISMATCH  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_RESPONSE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NO_ANSWERS   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NO_A_RECORD  = 3'd6;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} beat_t;

	typedef struct packed {
		logic                found;
		logic [ADDR_W-1:0]   address;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ===== sv/dnsa_in_reg.sv =====
// Input register of the extractor: holds one accepted payload beat.
// Depends on dnsa_pkg for the beat type.
module dnsa_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dnsa_pkg::beat_t in_beat,
	input  logic            advance,
	output logic            beat_valid,
	output dnsa_pkg::beat_t beat
);

	logic            valid_s1;
	dnsa_pkg::beat_t beat_s1;

	assign in_ready   = !valid_s1 || advance;
	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

// ===== sv/dnsa_parser.sv =====
// Parser state of the extractor: walks header, question and answers one
// beat per cycle while step is high and forms the result on the final beat. Depends on dnsa_pkg.
module dnsa_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  dnsa_pkg::beat_t               beat,
	input  logic                          listen_enable,
	input  logic [dnsa_pkg::WORD_W-1:0]   expected_id,
	output dnsa_pkg::result_t             result
);

	localparam int unsigned W  = dnsa_pkg::WORD_W;
	localparam int unsigned BW = dnsa_pkg::BYTE_W;
	localparam int unsigned AW = dnsa_pkg::ADDR_W;
	localparam int unsigned SW = dnsa_pkg::STATUS_W;

	localparam logic [W-1:0] OFS_ID_HI  = 16'd0;
	localparam logic [W-1:0] OFS_ID_LO  = 16'd1;
	localparam logic [W-1:0] OFS_FLAGS  = 16'd2;
	localparam logic [W-1:0] OFS_AN_HI  = 16'd6;
	localparam logic [W-1:0] OFS_AN_LO  = 16'd7;
	localparam logic [W-1:0] OFS_HDR_END = 16'd11;
	localparam logic [W-1:0] POS_TYPE_HI = 16'd0;
	localparam logic [W-1:0] POS_TYPE_LO = 16'd1;
	localparam logic [W-1:0] POS_LEN_HI  = 16'd8;
	localparam logic [W-1:0] POS_LEN_LO  = 16'd9;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_QNAME_LEN,
		PH_QNAME_SKIP,
		PH_QTAIL,
		PH_AN_FIRST,
		PH_AN_LEN,
		PH_AN_SKIP,
		PH_AN_PTR,
		PH_FIXED,
		PH_CAPTURE,
		PH_RD_SKIP,
		PH_DONE
	} phase_t;

	phase_t          phase_q, phase_nx;
	logic [W-1:0]    offset_q, offset_nx;
	logic [W-1:0]    skip_q, skip_nx;
	logic [W-1:0]    answers_q, answers_nx;
	logic [BW-1:0]   hi_q, hi_nx;
	logic [W-1:0]    rtype_q, rtype_nx;
	logic [W-1:0]    rlen_q, rlen_nx;
	logic [SW-1:0]   verdict_q, verdict_nx;
	logic            captured_q, captured_nx;
	logic [AW-1:0]   addr_q, addr_nx;
	logic [W-1:0]    skip_dec;
	logic [W-1:0]    answers_dec;
	logic [W-1:0]    pos;
	logic [W-1:0]    field;
	logic [W-1:0]    byte_w;
	logic [SW-1:0]   status;

	assign skip_dec    = skip_q - 16'd1;
	assign answers_dec = answers_q - 16'd1;
	assign pos         = dnsa_pkg::FIXED_BYTES - skip_q;
	assign field       = {hi_q, beat.data};
	assign byte_w      = {{(W-BW){1'b0}}, beat.data};

	always_comb begin
		phase_nx    = phase_q;
		skip_nx     = skip_q;
		answers_nx  = answers_q;
		hi_nx       = hi_q;
		rtype_nx    = rtype_q;
		rlen_nx     = rlen_q;
		verdict_nx  = verdict_q;
		captured_nx = captured_q;
		addr_nx     = addr_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (offset_q == OFS_ID_HI || offset_q == OFS_AN_HI) begin
					hi_nx = beat.data;
				end else if (offset_q == OFS_ID_LO) begin
					if (field != expected_id) verdict_nx = dnsa_pkg::ST_ID_MISMATCH;
				end else if (offset_q == OFS_FLAGS) begin
					if (verdict_q == dnsa_pkg::ST_FOUND && !beat.data[BW-1])
						verdict_nx = dnsa_pkg::ST_NOT_RESPONSE;
				end else if (offset_q == OFS_AN_LO) begin
					answers_nx = field;
				end else if (offset_q == OFS_HDR_END) begin
					if (verdict_q == dnsa_pkg::ST_FOUND && answers_q == '0)
						verdict_nx = dnsa_pkg::ST_NO_ANSWERS;
					phase_nx = (verdict_nx != dnsa_pkg::ST_FOUND) ? PH_DONE : PH_QNAME_LEN;
				end
			end
			PH_QNAME_LEN: begin
				if (beat.data == '0) begin
					skip_nx  = dnsa_pkg::QTAIL_BYTES;
					phase_nx = PH_QTAIL;
				end else begin
					skip_nx  = byte_w;
					phase_nx = PH_QNAME_SKIP;
				end
			end
			PH_QNAME_SKIP: begin
				skip_nx = skip_dec;
				if (skip_dec == '0) phase_nx = PH_QNAME_LEN;
			end
			PH_QTAIL: begin
				skip_nx = skip_dec;
				if (skip_dec == '0) phase_nx = PH_AN_FIRST;
			end
			PH_AN_FIRST, PH_AN_LEN: begin
				if (phase_q == PH_AN_FIRST
						&& (beat.data & dnsa_pkg::PTR_MASK) == dnsa_pkg::PTR_MASK) begin
					phase_nx = PH_AN_PTR;
				end else if (beat.data == '0) begin
					skip_nx  = dnsa_pkg::FIXED_BYTES;
					phase_nx = PH_FIXED;
				end else begin
					skip_nx  = byte_w;
					phase_nx = PH_AN_SKIP;
				end
			end
			PH_AN_SKIP: begin
				skip_nx = skip_dec;
				if (skip_dec == '0) phase_nx = PH_AN_LEN;
			end
			PH_AN_PTR: begin
				skip_nx  = dnsa_pkg::FIXED_BYTES;
				phase_nx = PH_FIXED;
			end
			PH_FIXED: begin
				if (pos == POS_TYPE_HI || pos == POS_LEN_HI) hi_nx = beat.data;
				else if (pos == POS_TYPE_LO) rtype_nx = field;
				else if (pos == POS_LEN_LO) rlen_nx = field;
				skip_nx = skip_dec;
				if (skip_dec == '0) begin
					if (rtype_nx == dnsa_pkg::TYPE_A && rlen_nx == dnsa_pkg::A_DATA_BYTES) begin
						skip_nx  = dnsa_pkg::A_DATA_BYTES;
						phase_nx = PH_CAPTURE;
					end else if (rlen_nx == '0) begin
						answers_nx = answers_dec;
						phase_nx   = (answers_dec == '0) ? PH_DONE : PH_AN_FIRST;
					end else begin
						skip_nx  = rlen_nx;
						phase_nx = PH_RD_SKIP;
					end
				end
			end
			PH_CAPTURE: begin
				addr_nx = {addr_q[AW-BW-1:0], beat.data};
				skip_nx = skip_dec;
				if (skip_dec == '0) begin
					captured_nx = 1'b1;
					phase_nx    = PH_DONE;
				end
			end
			PH_RD_SKIP: begin
				skip_nx = skip_dec;
				if (skip_dec == '0) begin
					answers_nx = answers_dec;
					phase_nx   = (answers_dec == '0) ? PH_DONE : PH_AN_FIRST;
				end
			end
			default: begin
			end
		endcase
		offset_nx = (offset_q != dnsa_pkg::OFFSET_MAX) ? offset_q + 16'd1 : offset_q;
	end

	always_comb begin
		priority if (!listen_enable) status = dnsa_pkg::ST_DISABLED;
		else if (offset_nx < dnsa_pkg::HEADER_BYTES) status = dnsa_pkg::ST_SHORT;
		else if (verdict_nx != dnsa_pkg::ST_FOUND) status = verdict_nx;
		else if (captured_nx) status = dnsa_pkg::ST_FOUND;
		else status = dnsa_pkg::ST_NO_A_RECORD;
		result.status  = status;
		result.found   = (status == dnsa_pkg::ST_FOUND);
		result.address = (status == dnsa_pkg::ST_FOUND) ? addr_nx : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			offset_q   <= '0;
			skip_q     <= '0;
			answers_q  <= '0;
			hi_q       <= '0;
			rtype_q    <= '0;
			rlen_q     <= '0;
			verdict_q  <= '0;
			captured_q <= 1'b0;
			addr_q     <= '0;
		end else if (step) begin
			if (beat.last) begin
				phase_q    <= PH_HEADER;
				offset_q   <= '0;
				skip_q     <= '0;
				answers_q  <= '0;
				hi_q       <= '0;
				rtype_q    <= '0;
				rlen_q     <= '0;
				verdict_q  <= '0;
				captured_q <= 1'b0;
				addr_q     <= '0;
			end else begin
				phase_q    <= phase_nx;
				offset_q   <= offset_nx;
				skip_q     <= skip_nx;
				answers_q  <= answers_nx;
				hi_q       <= hi_nx;
				rtype_q    <= rtype_nx;
				rlen_q     <= rlen_nx;
				verdict_q  <= verdict_nx;
				captured_q <= captured_nx;
				addr_q     <= addr_nx;
			end
		end
	end

endmodule

// ===== sv/dnsa_out_reg.sv =====
// Result register of the extractor: holds one result beat until it is taken.
// Depends on dnsa_pkg for the result type.
module dnsa_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dnsa_pkg::result_t result_in,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output dnsa_pkg::result_t result_out
);

	logic              valid_q;
	dnsa_pkg::result_t result_q;

	assign free       = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign result_out = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

// ===== sv/dns_reply_a_record_extractor_unit.sv =====
// Top level of the DNS reply A-record extractor.
// Instantiates dnsa_in_reg, dnsa_parser and dnsa_out_reg; uses dnsa_pkg.
//
// Usage: the payload of one DNS reply enters on the input channel one byte
// per beat (payload_byte), header first, with last_byte set on its final beat.
// Exactly one result beat (found, address, status) leaves on the output
// channel for each payload; no other input beat produces output.
// Before a payload, software writes listen_enable (index 0) and expected_id
// (index 1) through cfg_we/cfg_index/cfg_data while the block is idle.
// Throughput: one byte per cycle, set by the single parser step between the
// input register and the result register; a final byte waits there until the
// result register is free, then its result is loaded and can be taken.
// Reset clears the parser to the header phase, empties both registers and
// sets both configuration registers to zero.
// If the receiver stalls, the result is held; bytes of the next payload keep
// flowing until its own final byte reaches the parser, which then waits for
// the result register to be free, and the input channel backs up.
module dns_reply_a_record_extractor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dnsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dnsa_pkg::WORD_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dnsa_pkg::BYTE_W-1:0]       payload_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [dnsa_pkg::ADDR_W-1:0]       address,
	output logic [dnsa_pkg::STATUS_W-1:0]     status
);

	logic                          listen_enable_q;
	logic [dnsa_pkg::WORD_W-1:0]   expected_id_q;
	dnsa_pkg::beat_t               in_beat;
	dnsa_pkg::beat_t               beat;
	logic                          beat_valid;
	logic                          step;
	logic                          out_free;
	dnsa_pkg::result_t             result;
	dnsa_pkg::result_t             result_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_enable_q <= 1'b0;
			expected_id_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dnsa_pkg::REG_LISTEN_ENABLE: listen_enable_q <= cfg_data[0];
				dnsa_pkg::REG_EXPECTED_ID:   expected_id_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_beat.data = payload_byte;
	assign in_beat.last = last_byte;
	assign step         = beat_valid && (!beat.last || out_free);

	dnsa_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_beat    (in_beat),
		.advance    (step),
		.beat_valid (beat_valid),
		.beat       (beat)
	);

	dnsa_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.beat          (beat),
		.listen_enable (listen_enable_q),
		.expected_id   (expected_id_q),
		.result        (result)
	);

	dnsa_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step && beat.last),
		.result_in  (result),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_out (result_out)
	);

	assign found   = result_out.found;
	assign address = result_out.address;
	assign status  = result_out.status;

endmodule

// ===== sv/dnsa_checker.sv =====
// Port-level checks for the DNS reply A-record extractor, bound to its top
// level. Depends on dnsa_pkg and on dns_reply_a_record_extractor_unit.
module dnsa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              found,
	input logic [dnsa_pkg::ADDR_W-1:0]       address,
	input logic [dnsa_pkg::STATUS_W-1:0]     status
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(address)
			&& $stable(status))
		else $error("Stalled result beat changed.");

	a_found_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> found == (status == dnsa_pkg::ST_FOUND))
		else $error("Found flag disagrees with status.");

	a_address_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> address == '0)
		else $error("Address is nonzero without a capture.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= dnsa_pkg::ST_NO_A_RECORD)
		else $error("Status code out of range.");

endmodule

bind dns_reply_a_record_extractor_unit dnsa_checker u_dnsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.found     (found),
	.address   (address),
	.status    (status)
);
